@@ design/kkr_pkg.sv @@
// Shared types, constants and the romanization rule function.
`timescale 1ns / 1ps
package kkr_pkg;

  localparam int unsigned CharW = 16;
  localparam int unsigned MaxLetters = 4;
  localparam int unsigned QueueDepth = 2;

  typedef logic [CharW-1:0] char_t;

  typedef struct packed {
    char_t [MaxLetters-1:0] letters;
    logic [2:0] n_letters;
    logic [1:0] used;
  } rule_t;

  // Work item handed from the front part to the back part.
  typedef struct packed {
    char_t [MaxLetters-1:0] letters;
    logic [2:0] n_letters;
    logic run_end;
    logic str_end;
  } job_t;

  localparam char_t KSokuon = 16'h30C3;
  localparam char_t KN = 16'h30F3;
  localparam char_t KChoon = 16'h30FC;
  localparam char_t KU = 16'h30A6;
  localparam char_t KSya = 16'h30E3;
  localparam char_t KSyu = 16'h30E5;
  localparam char_t KSyo = 16'h30E7;
  localparam char_t KSe = 16'h30A7;
  localparam char_t KFirst = 16'h30A1;
  localparam char_t KLast = 16'h30F4;
  localparam char_t ChOmac = 16'h014D;
  localparam char_t ChUmac = 16'h016B;

  function automatic rule_t mk(input string s, input logic [1:0] u);
    rule_t r;
    r = '0;
    r.used = u;
    for (int i = 0; i < MaxLetters; i++) begin
      if (i < s.len()) r.letters[i] = char_t'(s[i]);
    end
    r.n_letters = 3'(s.len());
    return r;
  endfunction

  function automatic string base_text(input char_t c);
    string s;
    case (c)
      16'h30A1, 16'h30A2: s = "a";
      16'h30A3, 16'h30A4: s = "i";
      16'h30A5, 16'h30A6: s = "u";
      16'h30A7, 16'h30A8: s = "e";
      16'h30A9, 16'h30AA: s = "o";
      16'h30AB: s = "ka"; 16'h30AC: s = "ga"; 16'h30AD: s = "ki"; 16'h30AE: s = "gi";
      16'h30AF: s = "ku"; 16'h30B0: s = "gu"; 16'h30B1: s = "ke"; 16'h30B2: s = "ge";
      16'h30B3: s = "ko"; 16'h30B4: s = "go"; 16'h30B5: s = "sa"; 16'h30B6: s = "za";
      16'h30B7: s = "shi"; 16'h30B8: s = "ji"; 16'h30B9: s = "su"; 16'h30BA: s = "zu";
      16'h30BB: s = "se"; 16'h30BC: s = "ze"; 16'h30BD: s = "so"; 16'h30BE: s = "zo";
      16'h30BF: s = "ta"; 16'h30C0: s = "da"; 16'h30C1: s = "chi"; 16'h30C2: s = "ji";
      16'h30C4: s = "tsu"; 16'h30C5: s = "zu"; 16'h30C6: s = "te"; 16'h30C7: s = "de";
      16'h30C8: s = "to"; 16'h30C9: s = "do"; 16'h30CA: s = "na"; 16'h30CB: s = "ni";
      16'h30CC: s = "nu"; 16'h30CD: s = "ne"; 16'h30CE: s = "no"; 16'h30CF: s = "ha";
      16'h30D0: s = "ba"; 16'h30D1: s = "pa"; 16'h30D2: s = "hi"; 16'h30D3: s = "bi";
      16'h30D4: s = "pi"; 16'h30D5: s = "fu"; 16'h30D6: s = "bu"; 16'h30D7: s = "pu";
      16'h30D8: s = "he"; 16'h30D9: s = "be"; 16'h30DA: s = "pe"; 16'h30DB: s = "ho";
      16'h30DC: s = "bo"; 16'h30DD: s = "po"; 16'h30DE: s = "ma"; 16'h30DF: s = "mi";
      16'h30E0: s = "mu"; 16'h30E1: s = "me"; 16'h30E2: s = "mo";
      16'h30E3, 16'h30E4: s = "ya";
      16'h30E5, 16'h30E6: s = "yu";
      16'h30E7, 16'h30E8: s = "yo";
      16'h30E9: s = "ra"; 16'h30EA: s = "ri"; 16'h30EB: s = "ru"; 16'h30EC: s = "re";
      16'h30ED: s = "ro";
      16'h30EE, 16'h30EF: s = "wa";
      16'h30F0: s = "i"; 16'h30F1: s = "e"; 16'h30F2: s = "o"; 16'h30F4: s = "v";
      default: s = "";
    endcase
    return s;
  endfunction

  function automatic string seq2(input char_t a, input char_t b);
    string s;
    case ({a, b})
      {16'h30A4, 16'h30A3}: s = "yi"; {16'h30A4, 16'h30A7}: s = "ye";
      {16'h30A6, 16'h30A1}: s = "wa"; {16'h30A6, 16'h30A3}: s = "wi";
      {16'h30A6, 16'h30A5}: s = "wu"; {16'h30A6, 16'h30A7}: s = "we";
      {16'h30A6, 16'h30A9}: s = "wo"; {16'h30A6, 16'h30E5}: s = "wyu";
      {16'h30AF, 16'h30A1}: s = "kwa"; {16'h30AF, 16'h30A3}: s = "kwi";
      {16'h30AF, 16'h30A7}: s = "kwe"; {16'h30AF, 16'h30A9}: s = "kwo";
      {16'h30AF, 16'h30EE}: s = "kwa";
      {16'h30B0, 16'h30A1}: s = "gwa"; {16'h30B0, 16'h30A3}: s = "gwi";
      {16'h30B0, 16'h30A7}: s = "gwe"; {16'h30B0, 16'h30A9}: s = "gwo";
      {16'h30B0, 16'h30EE}: s = "gwa";
      {16'h30B9, 16'h30A3}: s = "si"; {16'h30BA, 16'h30A3}: s = "zi";
      {16'h30C4, 16'h30A1}: s = "tsa"; {16'h30C4, 16'h30A3}: s = "tsi";
      {16'h30C4, 16'h30A7}: s = "tse"; {16'h30C4, 16'h30A9}: s = "tso";
      {16'h30C4, 16'h30E5}: s = "tsyu";
      {16'h30C6, 16'h30A3}: s = "ti"; {16'h30C6, 16'h30A5}: s = "tu";
      {16'h30C6, 16'h30E5}: s = "tyu";
      {16'h30C7, 16'h30A3}: s = "di"; {16'h30C7, 16'h30E5}: s = "dyu";
      {16'h30D5, 16'h30E3}: s = "fya"; {16'h30D5, 16'h30E5}: s = "fyu";
      {16'h30D5, 16'h30E7}: s = "fyo"; {16'h30D5, 16'h30A1}: s = "fa";
      {16'h30D5, 16'h30A3}: s = "fi"; {16'h30D5, 16'h30A7}: s = "fe";
      {16'h30D5, 16'h30A9}: s = "fo";
      {16'h30DB, 16'h30A5}: s = "hu"; {16'h30C9, 16'h30A5}: s = "du";
      default: s = "";
    endcase
    return s;
  endfunction

  function automatic string yo_stem(input char_t c);
    string s;
    case (c)
      16'h30AD: s = "ky"; 16'h30B7: s = "sh"; 16'h30C1: s = "ch"; 16'h30CB: s = "ny";
      16'h30D2: s = "hy"; 16'h30DF: s = "my"; 16'h30EA: s = "ry"; 16'h30AE: s = "gy";
      16'h30B8: s = "j"; 16'h30D3: s = "by"; 16'h30D4: s = "py";
      default: s = "";
    endcase
    return s;
  endfunction

  function automatic logic is_long_o(input char_t c);
    logic r;
    case (c)
      16'h30AA, 16'h30B3, 16'h30BD, 16'h30C8, 16'h30CE, 16'h30DB, 16'h30E2,
      16'h30E8, 16'h30ED, 16'h30B4, 16'h30BE, 16'h30C9, 16'h30DC, 16'h30DD: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // One decision on the oldest unit with two units of lookahead.
  function automatic rule_t decide(input char_t c1, input char_t c2, input char_t c3);
    rule_t r;
    string s;
    string st;
    logic [1:0] u;
    r = mk("", 2'd1);
    s = seq2(c1, c2);
    st = yo_stem(c1);
    if ((c1 == 16'h30D5 || c1 == 16'h30F4) && c2 == 16'h30A3 && c3 == 16'h30A7) begin
      r = mk((c1 == 16'h30D5) ? "fye" : "vye", 2'd3);
    end else if (s.len() != 0) begin
      r = mk(s, 2'd2);
    end else if (st.len() != 0 && (c2 == KSya || c2 == KSyo || c2 == KSyu || c2 == KSe)) begin
      u = 2'd2;
      if (c2 == KSya) s = {st, "a"};
      else if (c2 == KSe) s = {st, "e"};
      else if (c3 == KU) begin
        s = {st, "x"};
        u = 2'd3;
      end else if (c2 == KSyo) s = {st, "o"};
      else s = {st, "u"};
      r = mk(s, u);
      if (u == 2'd3) r.letters[st.len()] = (c2 == KSyo) ? ChOmac : ChUmac;
    end else if (c2 == KU && is_long_o(c1)) begin
      s = base_text(c1);
      r = mk(s, 2'd2);
      r.letters[s.len() - 1] = ChOmac;
    end else if (c1 == KSokuon) begin
      case (c2)
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3: r = mk("k", 2'd1);
        16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD: r = mk("s", 2'd1);
        16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8: r = mk("t", 2'd1);
        16'h30D1, 16'h30D4, 16'h30D7, 16'h30DA, 16'h30DD: r = mk("p", 2'd1);
        default: r = mk("", 2'd1);
      endcase
    end else if (c1 == KN) begin
      case (c2)
        16'h30D0, 16'h30D3, 16'h30D6, 16'h30D9, 16'h30DC,
        16'h30D1, 16'h30D4, 16'h30D7, 16'h30DA, 16'h30DD,
        16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2: r = mk("m", 2'd1);
        16'h30E4, 16'h30E6, 16'h30E8, 16'h30A2,
        16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA: r = mk("n'", 2'd1);
        default: r = mk("n", 2'd1);
      endcase
    end else if (c1 == KChoon) begin
      r = mk("", 2'd1);
    end else if (c1 >= KFirst && c1 <= KLast) begin
      r = mk(base_text(c1), 2'd1);
    end else begin
      r = '0;
      r.used = 2'd1;
      r.letters[0] = c1;
      r.n_letters = 3'd1;
    end
    return r;
  endfunction

endpackage

@@ design/kkr_front.sv @@
// Front part: lookahead window, one decision per cycle unless the queue stalls, job issue.
`timescale 1ns / 1ps
module kkr_front
  import kkr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  char_t char_i,
  input  logic  last_i,
  input  logic  valid_i,
  output logic  ready_o,
  output job_t  job_o,
  output logic  job_valid_o,
  input  logic  job_ready_i
);

  char_t [2:0] win_q, win_d;
  logic [1:0] cnt_q, cnt_d;
  logic flush_q, flush_d;
  logic emitted_q, emitted_d;
  rule_t rule;
  char_t c2, c3;
  logic act, rem_zero, nonempty, tail_empty;
  logic [1:0] used;

  assign c2 = (cnt_q > 2'd1) ? win_q[1] : '0;
  assign c3 = (cnt_q > 2'd2) ? win_q[2] : '0;
  assign rule = decide(win_q[0], c2, c3);
  assign used = (rule.used > cnt_q) ? cnt_q : rule.used;
  assign rem_zero = (cnt_q == used);
  assign nonempty = (rule.n_letters != 3'd0);
  // decide when window full or flushing
  assign act = flush_q || (cnt_q == 2'd3);
  assign ready_o = !act;

  // units left after this decision emit nothing if all are choon or sokuon
  always_comb begin
    tail_empty = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) >= used && 2'(i) < cnt_q && win_q[i] != KChoon && win_q[i] != KSokuon)
        tail_empty = 1'b0;
    end
  end

  always_comb begin
    job_o = '0;
    job_o.letters = rule.letters;
    job_o.n_letters = rule.n_letters;
    job_valid_o = 1'b0;
    if (act) begin
      if (flush_q) begin
        job_o.run_end = tail_empty;
        job_o.str_end = tail_empty;
        job_valid_o = nonempty || (rem_zero && !emitted_q);
      end else begin
        job_o.run_end = 1'b1;
        job_valid_o = nonempty;
      end
    end
  end

  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    flush_d = flush_q;
    emitted_d = emitted_q;
    if (act && (job_ready_i || !job_valid_o)) begin
      case (used)
        2'd1: win_d = {win_q[2], win_q[2], win_q[1]};
        2'd2: win_d = {win_q[2], win_q[2], win_q[2]};
        default: win_d = win_q;
      endcase
      cnt_d = cnt_q - used;
      if (nonempty) emitted_d = 1'b1;
      if (flush_q && rem_zero) begin
        flush_d = 1'b0;
        emitted_d = 1'b0;
      end
    end else if (valid_i && ready_o) begin
      win_d[cnt_q] = char_i;
      cnt_d = cnt_q + 2'd1;
      flush_d = last_i;
      emitted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      flush_q <= 1'b0;
      emitted_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      flush_q <= flush_d;
      emitted_q <= emitted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

@@ design/kkr_queue.sv @@
// Job queue between front and back parts, two entries by default.
`timescale 1ns / 1ps
module kkr_queue
  import kkr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t wdata_i,
  input  logic wvalid_i,
  output logic wready_o,
  output job_t rdata_o,
  output logic rvalid_o,
  input  logic rready_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] n_q;
  logic wr, rd;

  assign wready_o = (n_q != (AW+1)'(Depth));
  assign rvalid_o = (n_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign wr = wvalid_i && wready_o;
  assign rd = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      n_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      n_q <= n_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wdata_i;
  end

endmodule

@@ design/kkr_back.sv @@
// Back part: serializes job letters onto the output register.
`timescale 1ns / 1ps
module kkr_back
  import kkr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  output logic [18:0] data_o,
  output logic       valid_o,
  input  logic       ready_i
);

  logic [2:0] idx_q, idx_d;
  logic out_v_q, out_v_d;
  logic [18:0] out_q, out_d;
  logic load, is_last;
  logic [1:0] sel;

  assign sel = idx_q[1:0];
  assign load = job_valid_i && (!out_v_q || ready_i);
  assign is_last = (job_i.n_letters == 3'd0) || (idx_q + 3'd1 >= job_i.n_letters);
  assign job_ready_o = load && is_last;

  always_comb begin
    idx_d = idx_q;
    out_v_d = out_v_q && !ready_i;
    out_d = out_q;
    if (load) begin
      out_v_d = 1'b1;
      if (job_i.n_letters == 3'd0) begin
        out_d = {1'b1, 1'b1, 1'b0, 16'h0000};
      end else begin
        out_d = {job_i.str_end && is_last, job_i.run_end && is_last, 1'b1,
                 job_i.letters[sel]};
      end
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign data_o = out_q;
  assign valid_o = out_v_q;

endmodule

@@ design/katakana_romanizer.sv @@
// Top level of the katakana to romaji stream converter.
//  channel | dir | payload
//  s_axis  | in  | tdata = in_char, tlast = in_last
//  m_axis  | out | tdata = out_char, tuser = {string_end, out_valid}, tlast = run_last
// A full or flushing window takes one decision per cycle unless the queue is full, and
// holds s_axis_tready low meanwhile, so no input is accepted in a cycle that decides.
// The first letter of a decision passes through the queue and then the output register.
// The back sends one letter per cycle while m_axis_tready allows: up to 4 per decision.
// Reset clears the window count, queue pointers and count, and the output valid flag.
// The queue lets the front keep deciding while the output stalls, until it is full.
`timescale 1ns / 1ps
module katakana_romanizer
  import kkr_pkg::*;
#(
  parameter int unsigned JobQueueDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // in_char
  input  logic        s_axis_tlast,  // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_char
  output logic [1:0]  m_axis_tuser,  // string_end, out_valid
  output logic        m_axis_tlast   // run_last
);

  job_t fj, qj;
  logic fv, fr, qv, qr;
  logic [18:0] bd;

  kkr_front u_front (
    .clk_i, .rst_ni, .char_i(s_axis_tdata), .last_i(s_axis_tlast),
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .job_o(fj), .job_valid_o(fv), .job_ready_i(fr)
  );

  kkr_queue #(.Depth(JobQueueDepth)) u_queue (
    .clk_i, .rst_ni, .wdata_i(fj), .wvalid_i(fv), .wready_o(fr),
    .rdata_o(qj), .rvalid_o(qv), .rready_i(qr)
  );

  kkr_back u_back (
    .clk_i, .rst_ni, .job_i(qj), .job_valid_i(qv), .job_ready_o(qr),
    .data_o(bd), .valid_o(m_axis_tvalid), .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = bd[15:0];
  assign m_axis_tuser = {bd[18], bd[16]};
  assign m_axis_tlast = bd[17];

endmodule

@@ design/katakana_romanizer_chk.sv @@
// Port-level checker for the romanizer, bound to the top level.
`timescale 1ns / 1ps
module katakana_romanizer_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("string end without run end");
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[1] && m_axis_tdata == 16'h0)
    else $error("bad empty marker");
endmodule

bind katakana_romanizer katakana_romanizer_chk u_chk (.*);
